// ----- hw/rtl/apsp_pkg.sv -----
// Shared types, constants and codes of the all-pairs shortest path block.
package apsp_pkg;

   // Matrix geometry: node indices are NODE_BITS wide, so the matrix holds
   // MAX_NODES rows of MAX_NODES entries addressed as {row, column}.
   localparam int MAX_NODES   = 128;
   localparam int NODE_BITS   = 7;
   localparam int COUNT_BITS  = 8;
   localparam int ADDR_BITS   = 2 * NODE_BITS;
   localparam int DEPTH       = 1 << ADDR_BITS;
   localparam int DIST_BITS   = 24;
   localparam int WEIGHT_BITS = 16;
   localparam int FUNC_BITS   = 2;

   localparam logic [DIST_BITS-1:0]  UNREACHABLE      = 24'd10000000;
   localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 8'd128;
   localparam logic [COUNT_BITS-1:0] MAX_NODES_COUNT  = COUNT_BITS'(MAX_NODES);

   // Item kinds.
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_EDGE  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_CLOSE = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_QUERY = 2'd3;

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [NODE_BITS-1:0]   src_node;
      logic [NODE_BITS-1:0]   dst_node;
      logic [WEIGHT_BITS-1:0] edge_weight;
   } req_payload_type;

   typedef struct packed {
      logic                 is_answer;
      logic [DIST_BITS-1:0] path_distance;
   } rsp_payload_type;

   // Request from the sequencer to the distance memory.
   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [DIST_BITS-1:0] wr_data;
      logic [ADDR_BITS-1:0] rd_addr_a;
      logic [ADDR_BITS-1:0] rd_addr_b;
   } ram_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_EDGE_RD,
      ST_EDGE_WR1,
      ST_EDGE_WR2,
      ST_QUERY_RD,
      ST_QUERY_DATA,
      ST_CL_FETCH,
      ST_CL_LOAD,
      ST_CL_SWEEP,
      ST_RESP
   } state_type;

endpackage

// ----- hw/rtl/apsp_dist_ram.sv -----
// Distance matrix memory: one write port and two registered read ports.
module apsp_dist_ram (
   input  logic                          clock,
   input  apsp_pkg::ram_req_type         ram_req,
   output logic [apsp_pkg::DIST_BITS-1:0] rd_data_a,
   output logic [apsp_pkg::DIST_BITS-1:0] rd_data_b
);
   import apsp_pkg::*;

   logic [DIST_BITS-1:0] mem [DEPTH];
   logic [DIST_BITS-1:0] rd_data_a_ff;
   logic [DIST_BITS-1:0] rd_data_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Both read ports deliver their word in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem[ram_req.rd_addr_a];
      rd_data_b_ff <= mem[ram_req.rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- hw/rtl/apsp_relax_unit.sv -----
// Shared relaxation unit: saturating sum through a node, then minimum with the stored distance.
module apsp_relax_unit (
   input  logic [apsp_pkg::DIST_BITS-1:0] via_dist,
   input  logic [apsp_pkg::DIST_BITS-1:0] step_dist,
   input  logic [apsp_pkg::DIST_BITS-1:0] cur_dist,
   output logic [apsp_pkg::DIST_BITS-1:0] best_dist
);
   import apsp_pkg::*;

   logic [DIST_BITS:0]   sum;
   logic [DIST_BITS-1:0] sat_sum;

   // A path longer than the unreachable value is no better than no path.
   assign sum     = {1'b0, via_dist} + {1'b0, step_dist};
   assign sat_sum = (sum > {1'b0, UNREACHABLE}) ? UNREACHABLE : sum[DIST_BITS-1:0];

   assign best_dist = (sat_sum < cur_dist) ? sat_sum : cur_dist;

endmodule

// ----- hw/rtl/all_pairs_shortest_path.sv -----
// Top level: sequencer of the all-pairs shortest path block around its memory and relaxation unit.
//
//   channel   direction   handshake        word
//   req_      in          valid / stall    func, src_node, dst_node, edge_weight
//   rsp_      out         valid / stall    is_answer, path_distance
//   csr_      in          valid / ready    node_count
//
// One item at a time. A closure fetches and then loads each row's distance to the
// intermediate node, then updates one column per cycle through the shared relaxation
// unit and the two-read-port memory. A clear writes one memory word per cycle, an edge
// reads its entry and writes both directions, and a query reads one entry.
// Reset is synchronous and leaves the matrix undefined until the first clear item.
// A stalled result waits in the output register; the next item is taken meanwhile.
module all_pairs_shortest_path (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  apsp_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output apsp_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [apsp_pkg::COUNT_BITS-1:0]     csr_data
);
   import apsp_pkg::*;

   state_type              state_ff, state_in;
   req_payload_type        op_ff, op_in;
   logic [NODE_BITS-1:0]   k_ff, k_in;
   logic [NODE_BITS-1:0]   i_ff, i_in;
   logic [NODE_BITS-1:0]   j_ff, j_in;
   logic [ADDR_BITS-1:0]   clr_ff, clr_in;
   logic [DIST_BITS-1:0]   dik_ff, dik_in;
   logic                   pend_ff, pend_in;
   logic [ADDR_BITS-1:0]   pend_addr_ff, pend_addr_in;
   logic [DIST_BITS-1:0]   dist_ff, dist_in;
   logic                   ans_ff, ans_in;
   logic [COUNT_BITS-1:0]  node_count_ff;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_payload_ff;

   logic [COUNT_BITS-1:0]  n_eff;
   logic [COUNT_BITS-1:0]  n_last;
   logic [NODE_BITS-1:0]   node_last;
   logic                   src_ok;
   logic                   dst_ok;
   logic                   rsp_load;
   ram_req_type            ram_req;
   logic [DIST_BITS-1:0]   rd_data_a;
   logic [DIST_BITS-1:0]   rd_data_b;
   logic [DIST_BITS-1:0]   relax_via;
   logic [DIST_BITS-1:0]   relax_step;
   logic [DIST_BITS-1:0]   relax_cur;
   logic [DIST_BITS-1:0]   relax_best;

   apsp_dist_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   apsp_relax_unit u_relax (
      .via_dist  (relax_via),
      .step_dist (relax_step),
      .cur_dist  (relax_cur),
      .best_dist (relax_best)
   );

   // Effective node count: zero acts as one, anything above the matrix size as the size.
   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = COUNT_BITS'(1);
      end else if (node_count_ff > MAX_NODES_COUNT) begin
         n_eff = MAX_NODES_COUNT;
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign n_last    = n_eff - COUNT_BITS'(1);
   assign node_last = n_last[NODE_BITS-1:0];
   assign src_ok    = {1'b0, req_payload.src_node} < n_eff;
   assign dst_ok    = {1'b0, req_payload.dst_node} < n_eff;

   // The edge minimum goes through the relaxation unit with a zero path to add.
   always_comb begin
      if (state_ff == ST_EDGE_WR1) begin
         relax_via  = '0;
         relax_step = {{(DIST_BITS-WEIGHT_BITS){1'b0}}, op_ff.edge_weight};
         relax_cur  = rd_data_a;
      end else begin
         relax_via  = dik_ff;
         relax_step = rd_data_a;
         relax_cur  = rd_data_b;
      end
   end

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         node_count_ff <= csr_data;
      end
   end

   // Sequencer state and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      k_ff         <= k_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      clr_ff       <= clr_in;
      dik_ff       <= dik_in;
      pend_addr_ff <= pend_addr_in;
      dist_ff      <= dist_in;
      ans_ff       <= ans_in;
   end

   // Next state, memory requests and counters.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      clr_in       = clr_ff;
      dik_in       = dik_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      dist_in      = dist_ff;
      ans_in       = ans_ff;
      req_stall    = 1'b1;
      ram_req      = '0;

      // The closure update issued in the previous cycle is written back now.
      if (pend_ff) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = pend_addr_ff;
         ram_req.wr_data = relax_best;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in   = req_payload;
               ans_in  = 1'b0;
               dist_in = '0;
               k_in    = '0;
               i_in    = '0;
               j_in    = '0;
               clr_in  = '0;
               unique case (req_payload.func)
                  FUNC_CLEAR: state_in = ST_CLEAR;
                  FUNC_EDGE:  state_in = (src_ok && dst_ok) ? ST_EDGE_RD : ST_RESP;
                  FUNC_CLOSE: state_in = ST_CL_FETCH;
                  FUNC_QUERY: begin
                     ans_in = 1'b1;
                     if (src_ok && dst_ok) begin
                        state_in = ST_QUERY_RD;
                     end else begin
                        dist_in  = UNREACHABLE;
                        state_in = ST_RESP;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         // One word per cycle; the diagonal is where row equals column.
         ST_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = clr_ff;
            ram_req.wr_data = (clr_ff[ADDR_BITS-1:NODE_BITS] == clr_ff[NODE_BITS-1:0]) ?
                              '0 : UNREACHABLE;
            clr_in = clr_ff + ADDR_BITS'(1);
            if (&clr_ff) begin
               state_in = ST_RESP;
            end
         end

         ST_EDGE_RD: begin
            ram_req.rd_addr_a = {op_ff.src_node, op_ff.dst_node};
            state_in          = ST_EDGE_WR1;
         end

         // Keep the smaller weight and mirror it into the opposite direction next cycle.
         ST_EDGE_WR1: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = {op_ff.src_node, op_ff.dst_node};
            ram_req.wr_data = relax_best;
            dik_in          = relax_best;
            state_in        = ST_EDGE_WR2;
         end

         ST_EDGE_WR2: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = {op_ff.dst_node, op_ff.src_node};
            ram_req.wr_data = dik_ff;
            state_in        = ST_RESP;
         end

         ST_QUERY_RD: begin
            ram_req.rd_addr_a = {op_ff.src_node, op_ff.dst_node};
            state_in          = ST_QUERY_DATA;
         end

         ST_QUERY_DATA: begin
            dist_in  = rd_data_a;
            state_in = ST_RESP;
         end

         // Each row starts by fetching its distance to the intermediate node.
         ST_CL_FETCH: begin
            ram_req.rd_addr_a = {i_ff, k_ff};
            state_in          = ST_CL_LOAD;
         end

         ST_CL_LOAD: begin
            dik_in   = rd_data_a;
            state_in = ST_CL_SWEEP;
         end

         // One column per cycle: read both operands now, write the minimum next cycle.
         ST_CL_SWEEP: begin
            ram_req.rd_addr_a = {k_ff, j_ff};
            ram_req.rd_addr_b = {i_ff, j_ff};
            pend_in           = 1'b1;
            pend_addr_in      = {i_ff, j_ff};
            j_in              = j_ff + NODE_BITS'(1);
            if (j_ff == node_last) begin
               j_in     = '0;
               state_in = ST_CL_FETCH;
               if (i_ff == node_last) begin
                  i_in = '0;
                  if (k_ff == node_last) begin
                     state_in = ST_RESP;
                  end else begin
                     k_in = k_ff + NODE_BITS'(1);
                  end
               end else begin
                  i_in = i_ff + NODE_BITS'(1);
               end
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: a result waits here while the next item is taken.
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff.is_answer     <= ans_ff;
         rsp_payload_ff.path_distance <= dist_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // An accepted word always starts work.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not leave idle");

   // No closure write-back is left over once the block is idle.
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!pend_ff && !ram_req.wr_en))
      else $error("memory written while idle");

   // A result only appears out of the response state.
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("result raised outside the response state");

   // Acknowledgements carry no distance.
   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.is_answer) |-> (rsp_payload_ff.path_distance == '0))
      else $error("acknowledgement carries a distance");
`endif

endmodule

// ----- dv/apsp_checker.sv -----
// Checker for the shortest path block: predicts each result word and compares it.
module apsp_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  apsp_pkg::req_payload_type       req_payload,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  apsp_pkg::rsp_payload_type       rsp_payload,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [apsp_pkg::COUNT_BITS-1:0] csr_data,
   output int                              mismatch_count,
   output int                              words_pending
);
   import apsp_pkg::*;

   // Our own copy of the distance matrix and of the node count register.
   logic [DIST_BITS-1:0]  dist_model [MAX_NODES][MAX_NODES];
   logic [COUNT_BITS-1:0] node_count_model;
   rsp_payload_type       expected_words [$];
   int                    error_total = 0;

   // A count of zero behaves as one node, and anything above the matrix size is clipped.
   function automatic int nodes_in_use();
      if (node_count_model == '0)
         return 1;
      if (node_count_model > MAX_NODES_COUNT)
         return MAX_NODES;
      return int'(node_count_model);
   endfunction

   // Applies one request word to the matrix and returns the word the block should answer.
   function automatic rsp_payload_type predict_word(input req_payload_type word);
      rsp_payload_type      outcome;
      logic [DIST_BITS-1:0] shorter;
      int                   n, k, i, j, via, a, b;
      n = nodes_in_use();
      a = int'(word.src_node);
      b = int'(word.dst_node);
      outcome = '0;
      case (word.func)
         FUNC_CLEAR: begin
            // The whole matrix is cleared, whatever the node count.
            for (i = 0; i < MAX_NODES; i++)
               for (j = 0; j < MAX_NODES; j++)
                  dist_model[i][j] = (i == j) ? '0 : UNREACHABLE;
         end
         FUNC_EDGE: begin
            // Edges touching an unused node are dropped; self edges keep the smaller value.
            if (a < n && b < n) begin
               shorter = dist_model[a][b];
               if (DIST_BITS'(word.edge_weight) < shorter)
                  shorter = DIST_BITS'(word.edge_weight);
               dist_model[a][b] = shorter;
               dist_model[b][a] = shorter;
            end
         end
         FUNC_CLOSE: begin
            // In-place relaxation through every intermediate node, sums saturating.
            for (k = 0; k < n; k++)
               for (i = 0; i < n; i++)
                  for (j = 0; j < n; j++) begin
                     via = int'(dist_model[i][k]) + int'(dist_model[k][j]);
                     if (via > int'(UNREACHABLE))
                        via = int'(UNREACHABLE);
                     if (via < int'(dist_model[i][j]))
                        dist_model[i][j] = DIST_BITS'(via);
                  end
         end
         default: begin
            outcome.is_answer = 1'b1;
            if (a >= n || b >= n)
               outcome.path_distance = UNREACHABLE;
            else
               outcome.path_distance = dist_model[a][b];
         end
      endcase
      return outcome;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      error_total++;
      if (error_total <= 10)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Watch all three channels on the rising edge and keep the expectations in order.
   always @(posedge clock) begin : watch
      rsp_payload_type oldest;
      rsp_payload_type predicted;
      if (reset) begin
         node_count_model = NODE_COUNT_RESET;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready)
            node_count_model = csr_data;
         if (req_valid && !req_stall) begin
            predicted = predict_word(req_payload);
            expected_words.insert(expected_words.size(), predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unrequested word, path_distance", 0,
                               int'(rsp_payload.path_distance));
            end else begin
               oldest = expected_words[0];
               expected_words.delete(0);
               if (rsp_payload.is_answer !== oldest.is_answer)
                  report_mismatch("is_answer", int'(oldest.is_answer),
                                  int'(rsp_payload.is_answer));
               if (rsp_payload.path_distance !== oldest.path_distance)
                  report_mismatch("path_distance", int'(oldest.path_distance),
                                  int'(rsp_payload.path_distance));
            end
         end
      end
      mismatch_count <= error_total;
      words_pending  <= expected_words.size();
   end

endmodule

// ----- dv/tb_all_pairs_shortest_path.sv -----
// Testbench top of the shortest path block: stimulus, stalls and the final verdict.
module tb_all_pairs_shortest_path;
   import apsp_pkg::*;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_data    = '0;
   int                    mismatch_count;
   int                    words_pending;

   // Sender bookkeeping and figures for the summary.
   int burst_left = 0;
   int active_n   = MAX_NODES;
   int kind_seen [4] = '{0, 0, 0, 0};
   int word_total = 0;
   int csr_writes = 0;
   int count_low  = 255;
   int count_high = 0;
   int stall_mode = 0;
   int stall_run  = 0;

   all_pairs_shortest_path uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   apsp_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run, well above the slowest legal run.
   initial begin
      #40000000;
      $display("end of test: mismatches");
      $finish;
   end

   // The receiver changes between no stalls, light stalls and heavy stalls.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_run  = $urandom_range(20, 200);
      end else begin
         stall_run--;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   function automatic int usable_nodes(input int value);
      if (value == 0)
         return 1;
      if (value > MAX_NODES)
         return MAX_NODES;
      return value;
   endfunction

   // Mostly a node in use, now and then any index at all.
   function automatic int pick_node(input int n);
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, MAX_NODES - 1);
      return $urandom_range(0, n - 1);
   endfunction

   // Small weights make closures interesting; the extremes and full range turn up too.
   function automatic int edge_cost();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 65535;
         2, 3:    return $urandom_range(0, 65535);
         default: return $urandom_range(1, 50);
      endcase
   endfunction

   // Sends one request word, in bursts with random gaps between them.
   task automatic send_word(input logic [FUNC_BITS-1:0] func, input int src, input int dst,
                            input int weight);
      req_payload_type word;
      int              gap;
      word.func        = func;
      word.src_node    = NODE_BITS'(src);
      word.dst_node    = NODE_BITS'(dst);
      word.edge_weight = WEIGHT_BITS'(weight);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid   <= 1'b1;
      req_payload <= word;
      do @(posedge clock); while (req_stall);
      burst_left--;
      kind_seen[func]++;
      word_total++;
   endtask

   // Stops sending and waits until every expected result word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   // Node count writes happen only with the block idle.
   task automatic set_node_count(input int value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= COUNT_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_n = usable_nodes(value);
      csr_writes++;
      if (value < count_low)
         count_low = value;
      if (value > count_high)
         count_high = value;
   endtask

   // One random scenario: node count, optional clear, edges with some noise, optional closure, queries.
   task automatic run_scenario();
      int count_value, edges, queries, i;
      case ($urandom_range(0, 9))
         0:       count_value = $urandom_range(0, 1);
         1:       count_value = $urandom_range(128, 255);
         2:       count_value = $urandom_range(13, 24);
         default: count_value = $urandom_range(2, 12);
      endcase
      set_node_count(count_value);
      if ($urandom_range(0, 1) == 0)
         send_word(FUNC_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127), edge_cost());
      edges = $urandom_range(1, (active_n > 12) ? 24 : 2 * active_n);
      for (i = 0; i < edges; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            // Noise: any non-clear kind with arbitrary fields; no long closures on big sets.
            case ($urandom_range(0, 2))
               0: send_word(FUNC_EDGE, $urandom_range(0, 127), $urandom_range(0, 127),
                            $urandom_range(0, 65535));
               1: send_word((active_n <= 24) ? FUNC_CLOSE : FUNC_QUERY,
                            $urandom_range(0, 127), $urandom_range(0, 127),
                            $urandom_range(0, 65535));
               default: send_word(FUNC_QUERY, $urandom_range(0, 127), $urandom_range(0, 127),
                                  $urandom_range(0, 65535));
            endcase
         end else begin
            send_word(FUNC_EDGE, pick_node(active_n), pick_node(active_n), edge_cost());
         end
      end
      if (active_n <= 24 && $urandom_range(0, 4) != 0)
         send_word(FUNC_CLOSE, $urandom_range(0, 127), $urandom_range(0, 127), edge_cost());
      if ($urandom_range(0, 3) == 0)
         drain();
      queries = $urandom_range(4, 8);
      for (i = 0; i < queries; i++)
         send_word(FUNC_QUERY, pick_node(active_n), pick_node(active_n), edge_cost());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset node count: extremes, minimum keeping and self edges.
      send_word(FUNC_CLEAR, 0, 0, 0);
      send_word(FUNC_EDGE, 0, 127, 65535);
      send_word(FUNC_EDGE, 127, 0, 0);
      send_word(FUNC_EDGE, 5, 5, 7);
      send_word(FUNC_EDGE, 1, 2, 65535);
      send_word(FUNC_EDGE, 1, 2, 100);
      send_word(FUNC_EDGE, 2, 1, 300);
      send_word(FUNC_QUERY, 0, 127, 0);
      send_word(FUNC_QUERY, 2, 1, 0);
      send_word(FUNC_QUERY, 3, 4, 65535);
      send_word(FUNC_QUERY, 5, 5, 0);

      // Four nodes: an edge past the last node is dropped, closure, out of range queries.
      set_node_count(4);
      send_word(FUNC_EDGE, 3, 4, 5);
      send_word(FUNC_EDGE, 0, 1, 10);
      send_word(FUNC_EDGE, 1, 3, 20);
      send_word(FUNC_CLOSE, 0, 0, 0);
      send_word(FUNC_QUERY, 0, 3, 0);
      send_word(FUNC_QUERY, 3, 0, 0);
      send_word(FUNC_QUERY, 0, 4, 0);
      send_word(FUNC_QUERY, 127, 127, 0);

      // A count of zero acts as a single node.
      set_node_count(0);
      send_word(FUNC_CLOSE, 127, 127, 65535);
      send_word(FUNC_QUERY, 0, 0, 0);
      send_word(FUNC_QUERY, 0, 1, 0);
      send_word(FUNC_EDGE, 0, 1, 3);

      // All bits set in the register act as the full matrix.
      set_node_count(255);
      send_word(FUNC_QUERY, 127, 0, 0);

      // Random scenarios until about a hundred words have gone in altogether.
      while (word_total < 100)
         run_scenario();

      drain();
      repeat (100) @(posedge clock);

      $display("Sent %0d words: %0d clears, %0d edges, %0d closures and %0d queries.",
               word_total, kind_seen[FUNC_CLEAR], kind_seen[FUNC_EDGE],
               kind_seen[FUNC_CLOSE], kind_seen[FUNC_QUERY]);
      $display("Node count written %0d times, values from %0d to %0d.",
               csr_writes, count_low, count_high);
      if (mismatch_count == 0 && words_pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
